// ----- hdl/trmv_pkg.sv -----
package trmv_pkg;

  // Window geometry.
  localparam int WINDOW_SIZE = 5;
  localparam int CNT_W       = $clog2(WINDOW_SIZE + 1);
  localparam int RANK_W      = $clog2(WINDOW_SIZE);

  // Field widths.
  localparam int RANGE_W    = 16;
  localparam int QUAT_W     = 16;
  localparam int HEIGHT_W   = 21;
  localparam int SPEED_W    = 24;
  localparam int PRESCALE_W = 8;
  localparam int GAIN_W     = 24;

  // Configuration port.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;
  localparam logic [CFG_INDEX_W-1:0] REG_PRESCALE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN     = 2'd1;
  localparam logic [PRESCALE_W-1:0]  PRESCALE_RESET = 8'd4;
  localparam logic [GAIN_W-1:0]      GAIN_RESET     = 24'd655360;

  // Datapath widths.
  localparam int SQ_W    = 2 * QUAT_W;
  localparam int TILT_W  = SQ_W + 1;
  localparam int R10_W   = RANGE_W + 4;
  localparam int LO_W    = 17;
  localparam int PLO_W   = R10_W + LO_W;
  localparam int PHI_W   = R10_W + 1 + TILT_W - LO_W;
  localparam int PROD_W  = PHI_W + LO_W;
  localparam int HEIGHT_SHIFT = 28;
  localparam int HSHIFT_W = PROD_W - HEIGHT_SHIFT;
  localparam int DIFF_W  = HEIGHT_W + 1;
  localparam int SPROD_W = DIFF_W + GAIN_W + 1;
  localparam int SPEED_SHIFT = 16;
  localparam int SSHIFT_W = SPROD_W - SPEED_SHIFT;

  localparam logic [PROD_W-1:0]  HEIGHT_HALF = PROD_W'(1) << (HEIGHT_SHIFT - 1);
  localparam logic [SPROD_W-1:0] SPEED_HALF  = SPROD_W'(1) << (SPEED_SHIFT - 1);

  localparam logic signed [HEIGHT_W-1:0] HEIGHT_MAX = 21'sd655350;
  localparam logic signed [HEIGHT_W-1:0] HEIGHT_MIN = -21'sd655350;
  localparam logic signed [SPEED_W-1:0]  SPEED_MAX  = 24'sh7FFFFF;
  localparam logic signed [SPEED_W-1:0]  SPEED_MIN  = 24'sh800000;

  // Counter constants.
  localparam logic [CNT_W-1:0]  CNT_ONE     = CNT_W'(1);
  localparam logic [CNT_W-1:0]  FILL_FULL   = CNT_W'(WINDOW_SIZE);
  localparam logic [CNT_W-1:0]  MEDIAN_RANK = CNT_W'(WINDOW_SIZE / 2);
  localparam logic [RANK_W-1:0] RANK_ONE    = RANK_W'(1);
  localparam logic [RANK_W-1:0] RANK_LAST   = RANK_W'(WINDOW_SIZE - 1);

  typedef struct packed {
    logic push;
    logic rotate;
  } cell_ctl_t;

endpackage

// ----- hdl/trmv_cell.sv -----
module trmv_cell (
  input  logic                                  clk,
  input  trmv_pkg::cell_ctl_t                   ctl,
  input  logic signed [trmv_pkg::HEIGHT_W-1:0]  value_in,
  input  logic signed [trmv_pkg::HEIGHT_W-1:0]  moving_in,
  output logic signed [trmv_pkg::HEIGHT_W-1:0]  value,
  output logic signed [trmv_pkg::HEIGHT_W-1:0]  moving,
  output logic        [trmv_pkg::CNT_W-1:0]     less_cnt,
  output logic        [trmv_pkg::CNT_W-1:0]     lesseq_cnt
);

  // The stored sample stays put while a copy of every window entry travels
  // past it around the ring; the two counts give this entry's rank.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      value      <= value_in;
      moving     <= value_in;
      less_cnt   <= '0;
      lesseq_cnt <= '0;
    end else if (ctl.rotate) begin
      moving <= moving_in;
      if (moving < value) begin
        less_cnt <= less_cnt + trmv_pkg::CNT_ONE;
      end
      if (moving <= value) begin
        lesseq_cnt <= lesseq_cnt + trmv_pkg::CNT_ONE;
      end
    end
  end

endmodule

// ----- hdl/tilt_range_median_velocity.sv -----
// Channel   Signals                                    Moves
// input     in_valid / in_ready                        range_cm, quat_w/x/y/z
// output    out_valid / out_ready                      height_median_mm, vertical_speed_mm_s
// config    cfg_valid / cfg_ready (always high)        cfg_index, cfg_data
//
// A request that only fills the window returns to idle after the push; once the window is full a
// request goes on through the rank pass, which rotates every sample once around the chain of
// cells, and then through the pick, speed and output states.
// Reset (rst, synchronous) empties the window and clears speed, prescale count and
// previous median; configuration returns to prescale 4 and gain 10.0.
// A finished result waits in the output register; the next request is taken while
// it waits, and the block stalls only when a new result finds the register still full.
module tilt_range_median_velocity (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic        [trmv_pkg::RANGE_W-1:0]      range_cm,
  input  logic signed [trmv_pkg::QUAT_W-1:0]       quat_w,
  input  logic signed [trmv_pkg::QUAT_W-1:0]       quat_x,
  input  logic signed [trmv_pkg::QUAT_W-1:0]       quat_y,
  input  logic signed [trmv_pkg::QUAT_W-1:0]       quat_z,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [trmv_pkg::HEIGHT_W-1:0]     height_median_mm,
  output logic signed [trmv_pkg::SPEED_W-1:0]      vertical_speed_mm_s,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic        [trmv_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic        [trmv_pkg::CFG_DATA_W-1:0]   cfg_data
);

  typedef enum logic [11:0] {
    S_IDLE      = 12'b0000_0000_0001,
    S_SQUARE    = 12'b0000_0000_0010,
    S_TILT      = 12'b0000_0000_0100,
    S_PART      = 12'b0000_0000_1000,
    S_SUM       = 12'b0000_0001_0000,
    S_ROUND     = 12'b0000_0010_0000,
    S_PUSH      = 12'b0000_0100_0000,
    S_RANK      = 12'b0000_1000_0000,
    S_PICK      = 12'b0001_0000_0000,
    S_SPEED     = 12'b0010_0000_0000,
    S_SPEED_RND = 12'b0100_0000_0000,
    S_OUTPUT    = 12'b1000_0000_0000
  } state_t;

  state_t state, state_next;

  // Configuration.
  logic [trmv_pkg::PRESCALE_W-1:0] prescale;
  logic [trmv_pkg::GAIN_W-1:0]     gain;

  // Captured request and arithmetic stages.
  logic        [trmv_pkg::RANGE_W-1:0]  range_q;
  logic signed [trmv_pkg::QUAT_W-1:0]   qw, qx, qy, qz;
  logic signed [trmv_pkg::SQ_W-1:0]     sq_w, sq_x, sq_y, sq_z;
  logic        [trmv_pkg::R10_W-1:0]    r10;
  logic signed [trmv_pkg::TILT_W-1:0]   tilt;
  logic        [trmv_pkg::PLO_W-1:0]    prod_lo;
  logic signed [trmv_pkg::PHI_W-1:0]    prod_hi;
  logic signed [trmv_pkg::PROD_W-1:0]   prod;
  logic        [trmv_pkg::PROD_W-1:0]   h_rnd;
  logic signed [trmv_pkg::HSHIFT_W-1:0] h_shift;
  logic signed [trmv_pkg::HEIGHT_W-1:0] height_sat;
  logic signed [trmv_pkg::HEIGHT_W-1:0] height;

  // Window and ranking.
  logic [trmv_pkg::CNT_W-1:0]  fill_count;
  logic [trmv_pkg::RANK_W-1:0] rank_cnt;
  logic                        window_full;
  trmv_pkg::cell_ctl_t         cell_ctl;
  logic signed [trmv_pkg::HEIGHT_W-1:0] cell_value  [trmv_pkg::WINDOW_SIZE];
  logic signed [trmv_pkg::HEIGHT_W-1:0] cell_moving [trmv_pkg::WINDOW_SIZE];
  logic        [trmv_pkg::CNT_W-1:0]    cell_less   [trmv_pkg::WINDOW_SIZE];
  logic        [trmv_pkg::CNT_W-1:0]    cell_lesseq [trmv_pkg::WINDOW_SIZE];
  logic        [trmv_pkg::WINDOW_SIZE-1:0] sel;
  logic signed [trmv_pkg::HEIGHT_W-1:0] pick_value;
  logic signed [trmv_pkg::HEIGHT_W-1:0] median;

  // Speed.
  logic [trmv_pkg::PRESCALE_W-1:0]      prescale_count;
  logic [trmv_pkg::PRESCALE_W-1:0]      period;
  logic                                 speed_update;
  logic signed [trmv_pkg::HEIGHT_W-1:0] previous_median;
  logic signed [trmv_pkg::SPEED_W-1:0]  held_speed;
  logic signed [trmv_pkg::DIFF_W-1:0]   diff;
  logic signed [trmv_pkg::SPROD_W-1:0]  spd_prod;
  logic        [trmv_pkg::SPROD_W-1:0]  s_rnd;
  logic signed [trmv_pkg::SSHIFT_W-1:0] s_shift;
  logic signed [trmv_pkg::SPEED_W-1:0]  speed_sat;

  logic out_free;

  assign in_ready    = (state == S_IDLE);
  assign cfg_ready   = 1'b1;
  assign window_full = (fill_count == trmv_pkg::FILL_FULL);
  assign out_free    = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_SQUARE;
        end
      end
      S_SQUARE:    state_next = S_TILT;
      S_TILT:      state_next = S_PART;
      S_PART:      state_next = S_SUM;
      S_SUM:       state_next = S_ROUND;
      S_ROUND:     state_next = S_PUSH;
      S_PUSH:      state_next = window_full ? S_RANK : S_IDLE;
      S_RANK: begin
        if (rank_cnt == trmv_pkg::RANK_LAST) begin
          state_next = S_PICK;
        end
      end
      S_PICK:      state_next = S_SPEED;
      S_SPEED:     state_next = S_SPEED_RND;
      S_SPEED_RND: state_next = S_OUTPUT;
      S_OUTPUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:     state_next = S_IDLE;
    endcase
  end

  // Height rounding: adding half minus one for negative values gives
  // round-to-nearest with ties away from zero under an arithmetic shift.
  always_comb begin
    h_rnd   = prod + trmv_pkg::HEIGHT_HALF
              - {{(trmv_pkg::PROD_W-1){1'b0}}, prod[trmv_pkg::PROD_W-1]};
    h_shift = h_rnd[trmv_pkg::PROD_W-1:trmv_pkg::HEIGHT_SHIFT];
    if (h_shift > trmv_pkg::HEIGHT_MAX) begin
      height_sat = trmv_pkg::HEIGHT_MAX;
    end else if (h_shift < trmv_pkg::HEIGHT_MIN) begin
      height_sat = trmv_pkg::HEIGHT_MIN;
    end else begin
      height_sat = h_shift[trmv_pkg::HEIGHT_W-1:0];
    end
  end

  always_comb begin
    s_rnd   = spd_prod + trmv_pkg::SPEED_HALF
              - {{(trmv_pkg::SPROD_W-1){1'b0}}, spd_prod[trmv_pkg::SPROD_W-1]};
    s_shift = s_rnd[trmv_pkg::SPROD_W-1:trmv_pkg::SPEED_SHIFT];
    if (s_shift > trmv_pkg::SPEED_MAX) begin
      speed_sat = trmv_pkg::SPEED_MAX;
    end else if (s_shift < trmv_pkg::SPEED_MIN) begin
      speed_sat = trmv_pkg::SPEED_MIN;
    end else begin
      speed_sat = s_shift[trmv_pkg::SPEED_W-1:0];
    end
  end

  assign diff   = {median[trmv_pkg::HEIGHT_W-1], median}
                - {previous_median[trmv_pkg::HEIGHT_W-1], previous_median};
  assign period = (prescale == '0) ? trmv_pkg::PRESCALE_W'(1) : prescale;
  assign speed_update = ({1'b0, prescale_count} + (trmv_pkg::PRESCALE_W + 1)'(1))
                        >= {1'b0, period};

  // Chain of cells: new samples shift in at cell 0, the rank pass rotates
  // the moving copies around the ring.
  assign cell_ctl.push   = (state == S_PUSH);
  assign cell_ctl.rotate = (state == S_RANK);

  for (genvar i = 0; i < trmv_pkg::WINDOW_SIZE; i++) begin : g_cell
    if (i == 0) begin : g_head
      trmv_cell u_cell (
        .clk        (clk),
        .ctl        (cell_ctl),
        .value_in   (height),
        .moving_in  (cell_moving[trmv_pkg::WINDOW_SIZE-1]),
        .value      (cell_value[i]),
        .moving     (cell_moving[i]),
        .less_cnt   (cell_less[i]),
        .lesseq_cnt (cell_lesseq[i])
      );
    end else begin : g_body
      trmv_cell u_cell (
        .clk        (clk),
        .ctl        (cell_ctl),
        .value_in   (cell_value[i-1]),
        .moving_in  (cell_moving[i-1]),
        .value      (cell_value[i]),
        .moving     (cell_moving[i]),
        .less_cnt   (cell_less[i]),
        .lesseq_cnt (cell_lesseq[i])
      );
    end
  end

  // Every cell whose rank interval covers the median rank holds the same
  // value, so an OR over the selected cells gives the median directly.
  always_comb begin
    pick_value = '0;
    for (int i = 0; i < trmv_pkg::WINDOW_SIZE; i++) begin
      sel[i] = (cell_less[i] <= trmv_pkg::MEDIAN_RANK)
            && (cell_lesseq[i] > trmv_pkg::MEDIAN_RANK);
      pick_value = pick_value | (sel[i] ? cell_value[i] : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      range_q <= range_cm;
      qw      <= quat_w;
      qx      <= quat_x;
      qy      <= quat_y;
      qz      <= quat_z;
    end
    if (state == S_SQUARE) begin
      sq_w <= qw * qw;
      sq_x <= qx * qx;
      sq_y <= qy * qy;
      sq_z <= qz * qz;
      r10  <= {1'b0, range_q, 3'b000} + {3'b000, range_q, 1'b0};
    end
    if (state == S_TILT) begin
      tilt <= {sq_w[trmv_pkg::SQ_W-1], sq_w} - {sq_x[trmv_pkg::SQ_W-1], sq_x}
            - {sq_y[trmv_pkg::SQ_W-1], sq_y} + {sq_z[trmv_pkg::SQ_W-1], sq_z};
    end
    // The wide product is split into a low unsigned and a high signed part.
    if (state == S_PART) begin
      prod_lo <= r10 * tilt[trmv_pkg::LO_W-1:0];
      prod_hi <= $signed({1'b0, r10}) * $signed(tilt[trmv_pkg::TILT_W-1:trmv_pkg::LO_W]);
    end
    if (state == S_SUM) begin
      prod <= {prod_hi, {trmv_pkg::LO_W{1'b0}}}
            + {{(trmv_pkg::PROD_W-trmv_pkg::PLO_W){1'b0}}, prod_lo};
    end
    if (state == S_ROUND) begin
      height <= height_sat;
    end
    if (state == S_PICK) begin
      median <= pick_value;
    end
    if (state == S_SPEED) begin
      spd_prod <= diff * $signed({1'b0, gain});
    end
    if (state == S_OUTPUT && out_free) begin
      height_median_mm    <= median;
      vertical_speed_mm_s <= held_speed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      prescale        <= trmv_pkg::PRESCALE_RESET;
      gain            <= trmv_pkg::GAIN_RESET;
      fill_count      <= '0;
      rank_cnt        <= '0;
      prescale_count  <= '0;
      previous_median <= '0;
      held_speed      <= '0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          trmv_pkg::REG_PRESCALE: prescale <= cfg_data[trmv_pkg::PRESCALE_W-1:0];
          trmv_pkg::REG_GAIN:     gain     <= cfg_data[trmv_pkg::GAIN_W-1:0];
          default: ;
        endcase
      end
      if (state == S_PUSH) begin
        rank_cnt <= '0;
        if (!window_full) begin
          fill_count <= fill_count + trmv_pkg::CNT_ONE;
        end
      end
      if (state == S_RANK) begin
        rank_cnt <= rank_cnt + trmv_pkg::RANK_ONE;
      end
      if (state == S_SPEED_RND) begin
        if (speed_update) begin
          held_speed      <= speed_sat;
          previous_median <= median;
          prescale_count  <= '0;
        end else begin
          prescale_count <= prescale_count + trmv_pkg::PRESCALE_W'(1);
        end
      end
      if (state == S_OUTPUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_median_found: assert property (@(posedge clk) disable iff (rst)
    (state == S_PICK) |-> (sel != '0))
    else $error("rank pass selected no median cell");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= trmv_pkg::FILL_FULL)
    else $error("fill count beyond window size");

  a_result_needs_full: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> window_full)
    else $error("result produced before the window filled");

  a_fill_no_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUSH && !window_full) |=> (state == S_IDLE))
    else $error("filling request went on to produce a result");
`endif

endmodule
